// File: design/height_grid_obstacle_classifier_macros.svh
// Assertion macros for the height grid obstacle classifier.
// Included by the top level; expects clk and rst_n in scope.
`ifndef HEIGHT_GRID_OBSTACLE_CLASSIFIER_MACROS_SVH
`define HEIGHT_GRID_OBSTACLE_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define HGOC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgoc assertion failed");
`define HGOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgoc assertion failed");
`else
`define HGOC_ASSERT_SAME(label, ante, cons)
`define HGOC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/hgoc_pkg.sv
// Shared types and constants of the height grid obstacle classifier.
// No dependencies; used by hgoc_div and the top level.
package hgoc_pkg;

    localparam int GRID_MAX_DEF   = 256;
    localparam int COORD_BITS_DEF = 16;

    localparam int CELL_W   = 10;
    localparam int GRID_W   = 9;
    localparam int THR_W    = 14;
    localparam int OUT_XY_W = 20;
    localparam int OUT_Z_W  = 16;

    localparam logic [CELL_W-1:0] CELL_RST = CELL_W'(100);
    localparam logic [GRID_W-1:0] GRID_RST = GRID_W'(200);
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(250);

    typedef enum logic [1:0] {
        REG_CELL = 2'd0,
        REG_GRID = 2'd1,
        REG_THR  = 2'd2,
        REG_MODE = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_BUILD    = 2'd0,
        ACT_CLASSIFY = 2'd1,
        ACT_READ     = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_OBS_PT   = 2'd0,
        KIND_CLR_PT   = 2'd1,
        KIND_OBS_CELL = 2'd2,
        KIND_CLR_CELL = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [OUT_XY_W-1:0] x;
        logic [OUT_XY_W-1:0] y;
        logic [OUT_Z_W-1:0]  z;
        logic                last;
    } rsp_t;

endpackage

// File: design/hgoc_div.sv
// Restoring divider: signed coordinate magnitude over the cell size, one bit a cycle.
// Depends on hgoc_pkg.
module hgoc_div #(
    parameter int COORD_BITS = hgoc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [COORD_BITS-1:0]         dividend,
    input  logic [hgoc_pkg::CELL_W-1:0]   divisor,
    output logic                          done,
    output logic [COORD_BITS-1:0]         quot,
    output logic                          rem_nz
);
    import hgoc_pkg::*;

    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] num_reg, num_next;
    logic [CELL_W-1:0]     rem_reg, rem_next;
    logic [CELL_W-1:0]     den_reg, den_next;
    logic [CELL_W:0]       trial;
    logic                  ge;

    assign trial = {rem_reg, num_reg[COORD_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(COORD_BITS);
            num_next  = dividend[COORD_BITS-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            rem_next = ge ? CELL_W'(trial - {1'b0, den_reg}) : trial[CELL_W-1:0];
            num_next = {num_reg[COORD_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign quot   = num_reg;
    assign rem_nz = |rem_reg;

endmodule

// File: design/height_grid_obstacle_classifier.sv
// Height grid obstacle classifier: top level with the cell memory and sequencer.
// Depends on hgoc_pkg, hgoc_div and height_grid_obstacle_classifier_macros.svh.
//
// Usage:
//  - Requests arrive on req_valid/req_stall with action and point or cell fields.
//    A request is taken when req_valid is high and req_stall is low.
//  - Results leave on rsp_valid/rsp_stall; last marks the final result of a request.
//  - Write settings over the APB port only while the block is idle (unchecked).
//  - One request is worked at a time. Build and classify run two restoring
//    dividers in parallel, one quotient bit per cycle. A cell read goes through
//    the memory read and the modify step.
//  - All cell state lives in one synchronous memory of GRID_MAX*GRID_MAX words
//    (valid, obstacle-seen, clear-seen, max and min height). Build, and
//    mode-0 classify of a valid cell, write back the word they read and modify.
//  - After reset, and for each clear request, a sweep writes every word empty,
//    one word a cycle, and req_stall stays high until the sweep ends. Settings
//    are still taken.
//  - Results go to an output register plus one spare slot, so a new request is
//    taken while a result still waits. When the receiver stalls, the block
//    holds results and stops only when it has a result that does not fit.
`include "height_grid_obstacle_classifier_macros.svh"
module height_grid_obstacle_classifier #(
    parameter int GRID_MAX   = hgoc_pkg::GRID_MAX_DEF,
    parameter int COORD_BITS = hgoc_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // requests
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     action,
    input  logic signed [COORD_BITS-1:0]   point_x,
    input  logic signed [COORD_BITS-1:0]   point_y,
    input  logic signed [COORD_BITS-1:0]   point_z,
    input  logic [7:0]                     cell_row,
    input  logic [7:0]                     cell_col,
    // results
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [1:0]                     kind,
    output logic signed [hgoc_pkg::OUT_XY_W-1:0] out_x,
    output logic signed [hgoc_pkg::OUT_XY_W-1:0] out_y,
    output logic signed [hgoc_pkg::OUT_Z_W-1:0]  out_z,
    output logic                           last
);
    import hgoc_pkg::*;

    localparam int CELLS  = GRID_MAX * GRID_MAX;
    localparam int AW     = $clog2(CELLS);
    localparam int IW     = $clog2(GRID_MAX);
    localparam int GW     = (GRID_W > $clog2(GRID_MAX + 1)) ? GRID_W : $clog2(GRID_MAX + 1);
    localparam int VW     = ((COORD_BITS > GW) ? COORD_BITS : GW) + 2;
    localparam int WORD_W = 3 + 2 * COORD_BITS;
    localparam int PW     = (COORD_BITS + 1 > OUT_XY_W) ? COORD_BITS + 1 : OUT_XY_W;
    localparam int ZW     = (COORD_BITS > OUT_Z_W) ? COORD_BITS : OUT_Z_W;
    localparam int SW     = GW + 2;
    localparam int PRW    = SW + CELL_W + 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_MOD   = 5'b10000
    } state_t;

    typedef struct packed {
        logic          ok;
        logic [IW-1:0] idx;
    } axis_t;

    // trunc(G/2 + coord/C) toward zero from the magnitude quotient
    function automatic axis_t axis_index(input logic [COORD_BITS-1:0] qm,
                                         input logic nz, input logic neg,
                                         input logic [GW-1:0] g);
        logic signed [VW-1:0] fq;
        logic signed [VW-1:0] v;
        axis_t r;
        fq = $signed(VW'(qm));
        if (neg)
            fq = -fq - $signed(VW'(nz));
        v = $signed(VW'(g >> 1)) + fq;
        if (v == '1 && nz)
            v = '0;
        r.ok  = !v[VW-1] && (v < $signed(VW'(g)));
        r.idx = v[IW-1:0];
        return r;
    endfunction

    // configuration registers
    logic [CELL_W-1:0] cell_reg;
    logic [GRID_W-1:0] grid_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              mode_reg;
    logic              cfg_wr;
    logic [CELL_W-1:0] c_eff;
    logic [GW-1:0]     g_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign c_eff  = (cell_reg == '0) ? CELL_W'(1) : cell_reg;
    assign g_eff  = (int'(grid_reg) > GRID_MAX) ? GW'(GRID_MAX) : GW'(grid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= CELL_RST;
            grid_reg <= GRID_RST;
            thr_reg  <= THR_RST;
            mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_CELL: cell_reg <= pwdata[CELL_W-1:0];
                REG_GRID: grid_reg <= pwdata[GRID_W-1:0];
                REG_THR:  thr_reg  <= pwdata[THR_W-1:0];
                REG_MODE: mode_reg <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_CELL: prdata = 32'(cell_reg);
            REG_GRID: prdata = 32'(grid_reg);
            REG_THR:  prdata = 32'(thr_reg);
            REG_MODE: prdata = 32'(mode_reg);
            default:  prdata = '0;
        endcase
    end

    // sequencer and held request
    state_t state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [1:0]    act_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [7:0]    row_reg, col_reg;
    logic          req_take;
    logic          div_start;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign div_start = req_take && (action == ACT_BUILD || action == ACT_CLASSIFY);

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            act_reg <= action;
            px_reg  <= point_x;
            py_reg  <= point_y;
            pz_reg  <= point_z;
            row_reg <= cell_row;
            col_reg <= cell_col;
        end
    end

    // dividers for the two axes
    logic                  div_done, div_done_y;
    logic [COORD_BITS-1:0] qx, qy;
    logic                  nzx, nzy;
    axis_t                 ax, ay;

    hgoc_div #(.COORD_BITS(COORD_BITS)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(point_x),
        .divisor(c_eff), .done(div_done), .quot(qx), .rem_nz(nzx)
    );

    hgoc_div #(.COORD_BITS(COORD_BITS)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(point_y),
        .divisor(c_eff), .done(div_done_y), .quot(qy), .rem_nz(nzy)
    );

    assign ax = axis_index(qx, nzx, px_reg[COORD_BITS-1], g_eff);
    assign ay = axis_index(qy, nzy, py_reg[COORD_BITS-1], g_eff);

    // cell memory: {valid, obstacle seen, clear seen, max, min}
    logic [WORD_W-1:0] mem [CELLS];
    logic [WORD_W-1:0] rd_q;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        rd_q <= mem[addr_reg];
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
    end

    logic c_valid, c_obs, c_clr;
    logic signed [COORD_BITS-1:0] c_max, c_min;
    logic signed [COORD_BITS+1:0] spread;
    logic          is_obs;

    assign c_valid = rd_q[WORD_W-1];
    assign c_obs   = rd_q[WORD_W-2];
    assign c_clr   = rd_q[WORD_W-3];
    assign c_max   = rd_q[2*COORD_BITS-1:COORD_BITS];
    assign c_min   = rd_q[COORD_BITS-1:0];
    assign spread  = (COORD_BITS+2)'(c_max) - (COORD_BITS+2)'(c_min);
    assign is_obs  = spread > $signed((COORD_BITS+2)'(thr_reg));

    // result fields
    logic signed [PW-1:0]  px2, py2;
    logic signed [ZW-1:0]  pz_ext;
    logic signed [SW-1:0]  sr, sc;
    logic signed [PRW-1:0] cx, cy;

    assign px2    = PW'(px_reg) <<< 1;
    assign py2    = PW'(py_reg) <<< 1;
    assign pz_ext = ZW'(pz_reg);
    assign sr     = $signed(SW'({row_reg, 1'b1})) - $signed(SW'(g_eff));
    assign sc     = $signed(SW'({col_reg, 1'b1})) - $signed(SW'(g_eff));
    assign cx     = PRW'(sr) * $signed(PRW'(c_eff));
    assign cy     = PRW'(sc) * $signed(PRW'(c_eff));

    // output register and spare slot
    rsp_t out_reg, out_next, pend_reg, pend_next;
    logic out_vld_reg, out_vld_next, pend_vld_reg, pend_vld_next;
    logic rsp_take, can_load, mod_go;
    logic [1:0] n_res;
    rsp_t res0, res1;
    logic [WORD_W-1:0] upd_word;

    assign rsp_take = out_vld_reg && !rsp_stall;
    assign can_load = !pend_vld_reg && (!out_vld_reg || rsp_take);
    assign mod_go   = (n_res == 2'd0) || can_load;

    // modify step: results and write-back word for the cell just read
    always_comb
    begin
        n_res    = 2'd0;
        res0     = '0;
        res1     = '0;
        upd_word = rd_q;
        mem_we   = 1'b0;
        res0.x   = px2[OUT_XY_W-1:0];
        res0.y   = py2[OUT_XY_W-1:0];
        res0.z   = pz_ext[OUT_Z_W-1:0];
        res0.last = 1'b1;
        case (action_t'(act_reg))
            ACT_BUILD:
            begin
                if (!c_valid)
                begin
                    upd_word = {1'b1, c_obs, c_clr, pz_reg, pz_reg};
                end
                else
                begin
                    upd_word = {1'b1, c_obs, c_clr,
                                (pz_reg > c_max) ? pz_reg : c_max,
                                (pz_reg < c_min) ? pz_reg : c_min};
                end
                mem_we = 1'b1;
            end
            ACT_CLASSIFY:
            begin
                if (c_valid && mode_reg)
                begin
                    n_res     = 2'd1;
                    res0.kind = is_obs ? KIND_OBS_PT : KIND_CLR_PT;
                end
                else if (c_valid)
                begin
                    upd_word = {1'b1, c_obs | is_obs, c_clr | !is_obs, c_max, c_min};
                    mem_we   = 1'b1;
                end
            end
            ACT_READ:
            begin
                res0.x    = cx[OUT_XY_W-1:0];
                res0.y    = cy[OUT_XY_W-1:0];
                res0.z    = OUT_Z_W'(thr_reg);
                res1      = res0;
                res1.kind = KIND_CLR_CELL;
                if (c_obs)
                begin
                    res0.kind = KIND_OBS_CELL;
                    res0.last = !c_clr;
                    n_res     = c_clr ? 2'd2 : 2'd1;
                end
                else if (c_clr)
                begin
                    res0.kind = KIND_CLR_CELL;
                    n_res     = 2'd1;
                end
            end
            default: ;
        endcase
        if (state_reg == ST_CLEAR)
        begin
            upd_word = '0;
            mem_we   = 1'b1;
        end
        else if (state_reg != ST_MOD || !mod_go)
        begin
            mem_we = 1'b0;
        end
    end

    assign mem_wdata = upd_word;

    always_comb
    begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        if (rsp_take)
        begin
            if (pend_vld_reg)
            begin
                out_next      = pend_reg;
                pend_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        if (state_reg == ST_MOD && can_load && n_res != 2'd0)
        begin
            out_next     = res0;
            out_vld_next = 1'b1;
            if (n_res == 2'd2)
            begin
                pend_next     = res1;
                pend_vld_next = 1'b1;
            end
        end
    end

    // sequencer: sweep, take request, divide, read, modify
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    case (action_t'(action))
                        ACT_BUILD, ACT_CLASSIFY: state_next = ST_DIV;
                        ACT_READ:
                        begin
                            if (GW'(cell_row) < g_eff && GW'(cell_col) < g_eff)
                            begin
                                addr_next  = AW'(IW'(cell_row)) * AW'(GRID_MAX)
                                           + AW'(IW'(cell_col));
                                state_next = ST_READ;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    addr_next  = AW'(ax.idx) * AW'(GRID_MAX) + AW'(ay.idx);
                    state_next = (ax.ok && ay.ok) ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: state_next = ST_MOD;
            ST_MOD:
            begin
                if (mod_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign rsp_valid = out_vld_reg;
    assign kind      = out_reg.kind;
    assign out_x     = out_reg.x;
    assign out_y     = out_reg.y;
    assign out_z     = out_reg.z;
    assign last      = out_reg.last;

    `HGOC_ASSERT_SAME(a_pend_needs_out, pend_vld_reg, out_vld_reg)
    `HGOC_ASSERT_SAME(a_sweep_stalls, state_reg == ST_CLEAR, req_stall)
    `HGOC_ASSERT_NEXT(a_point_divides, div_start, state_reg == ST_DIV)
    `HGOC_ASSERT_SAME(a_write_place, mem_we, state_reg == ST_CLEAR || state_reg == ST_MOD)
    `HGOC_ASSERT_NEXT(a_read_then_mod, state_reg == ST_READ, state_reg == ST_MOD)
    `HGOC_ASSERT_SAME(a_divs_in_step, div_done, div_done_y)

endmodule
